// ===== hw/rtl/tps_pkg.sv =====
// Package with types, constants and command codes of the task scheduler core.
`timescale 1ns / 1ps
package tps_pkg;
  localparam int MaxTasks = 16;
  localparam int SlotW = $clog2(MaxTasks);
  localparam int CntW = $clog2(MaxTasks + 1);
  localparam logic [31:0] TimeLimit = 32'h7FFF_FFFF;

  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP = 3'd2;
  localparam logic [2:0] CMD_SUSPEND = 3'd3;
  localparam logic [2:0] CMD_RESUME = 3'd4;
  localparam logic [2:0] CMD_SETPRIO = 3'd5;
  localparam logic [2:0] CMD_SCHED = 3'd6;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] HINT_NONE = 2'd0;
  localparam logic [1:0] HINT_IDLE = 2'd1;
  localparam logic [1:0] HINT_DEEP = 2'd2;

  // One table entry as stored in the task memory.
  typedef struct packed {
    logic [7:0] id;
    logic [31:0] due;
    logic [15:0] period;
    logic [7:0] prio;
    logic susp;
    logic rep;
    logic [SlotW-1:0] age;
  } entry_t;

  localparam int EntryW = $bits(entry_t);
endpackage

// ===== hw/rtl/tps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tps_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/tick_priority_task_scheduler_core.sv =====
// Top level of the tick-driven priority task scheduler core.
`timescale 1ns / 1ps
// Each request is handled by a sequencer that sweeps the task memory one
// entry per cycle through a single RAM read port with registered read data.
// A tick needs no scan: it runs one rewrite sweep. Every other command but
// the unused code, which goes straight to the response, scans the table and
// then decides in S_DECIDE, where start, suspend, resume, set priority and a
// schedule that rearms a repeating task write their entry. Stop and a schedule
// that removes a one-shot task add a second sweep to renumber the ages. The
// S_RESP state then raises the response valid. The response is held in the
// response register; the next request is taken once it has been delivered.
// Valid bits are kept in flip-flops, so no clearing pass is needed after reset.
module tick_priority_task_scheduler_core
  import tps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[2:0], task_id[10:3], timeout[26:11], priority_req[34:27], repeat_req[35]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], dispatched[2], dispatched_id[10:3], active_count[15:11],
  // sleep_hint[17:16]
  output logic [23:0] out_tdata
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic [MaxTasks-1:0] valid_r, valid_nxt;
  logic [31:0] time_r, time_nxt;
  logic dse_r;
  logic wrap_r, wrap_nxt;

  logic [2:0] cmd_r;
  logic [7:0] id_r;
  logic [15:0] tmo_r;
  logic [7:0] prio_r;
  logic rep_r;

  logic found_r, found_nxt, free_ok_r, free_ok_nxt, best_ok_r, best_ok_nxt;
  logic [SlotW-1:0] found_slot_r, found_slot_nxt, free_slot_r, free_slot_nxt;
  logic [SlotW-1:0] best_slot_r, best_slot_nxt;
  logic [SlotW-1:0] found_age_r, found_age_nxt;
  logic [CntW-1:0] count_r, count_nxt, active_r, active_nxt;
  entry_t found_e_r, found_e_nxt, best_e_r, best_e_nxt;
  logic [SlotW-1:0] rm_age_r, rm_age_nxt;
  logic rm_r, rm_nxt;

  logic [23:0] out_r, out_nxt;
  logic ov_r, ov_nxt;

  logic we;
  logic [SlotW-1:0] waddr, raddr;
  entry_t wdata, rdata;

  tps_ram #(.Width(EntryW), .Depth(MaxTasks)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata = out_r;

  // The read address is the index of the next entry; rdata holds the one being examined, at idx_r - 1.
  assign raddr = idx_r[SlotW-1:0];

  logic [CntW-1:0] pidx;
  logic [SlotW-1:0] pslot;
  logic pv;
  logic is_due;
  assign pidx = idx_r - CntW'(1);
  assign pslot = pidx[SlotW-1:0];
  assign pv = (idx_r != '0) && (idx_r <= CntW'(MaxTasks)) && valid_r[pslot];
  assign is_due = time_r >= rdata.due;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    valid_nxt = valid_r;
    time_nxt = time_r;
    wrap_nxt = wrap_r;
    found_nxt = found_r;
    found_slot_nxt = found_slot_r;
    found_age_nxt = found_age_r;
    found_e_nxt = found_e_r;
    free_ok_nxt = free_ok_r;
    free_slot_nxt = free_slot_r;
    best_ok_nxt = best_ok_r;
    best_slot_nxt = best_slot_r;
    best_e_nxt = best_e_r;
    count_nxt = count_r;
    active_nxt = active_r;
    rm_nxt = rm_r;
    rm_age_nxt = rm_age_r;
    out_nxt = out_r;
    ov_nxt = ov_r;
    we = 1'b0;
    waddr = pslot;
    wdata = rdata;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          idx_nxt = '0;
          found_nxt = 1'b0;
          free_ok_nxt = 1'b0;
          best_ok_nxt = 1'b0;
          count_nxt = '0;
          active_nxt = '0;
          rm_nxt = 1'b0;
          out_nxt = '0;
          wrap_nxt = 1'b0;
          if (in_tdata[2:0] == CMD_TICK) begin
            if (time_r == TimeLimit) begin
              time_nxt = '0;
              wrap_nxt = 1'b1;
            end else begin
              time_nxt = time_r + 32'd1;
            end
            state_nxt = S_SWEEP;
          end else if (in_tdata[2:0] == CMD_UNUSED) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pv) begin
          count_nxt = count_r + CntW'(1);
          if (!rdata.susp) begin
            active_nxt = active_r + CntW'(1);
          end
          if (!found_r && rdata.id == id_r) begin
            found_nxt = 1'b1;
            found_slot_nxt = pslot;
            found_age_nxt = rdata.age;
            found_e_nxt = rdata;
          end
          if (is_due && (!best_ok_r || rdata.prio > best_e_r.prio ||
              (rdata.prio == best_e_r.prio && rdata.age < best_e_r.age))) begin
            best_ok_nxt = 1'b1;
            best_slot_nxt = pslot;
            best_e_nxt = rdata;
          end
        end else if (idx_r != '0 && !free_ok_r) begin
          free_ok_nxt = 1'b1;
          free_slot_nxt = pslot;
        end
        if (idx_r == CntW'(MaxTasks)) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r + CntW'(1);
        end
      end
      S_DECIDE: begin
        state_nxt = S_RESP;
        case (cmd_r)
          CMD_START: begin
            wdata.due = time_r + {16'd0, tmo_r};
            wdata.period = tmo_r;
            wdata.prio = prio_r;
            wdata.susp = 1'b0;
            wdata.rep = rep_r;
            wdata.id = id_r;
            if (found_r) begin
              we = 1'b1;
              waddr = found_slot_r;
              wdata.age = found_age_r;
            end else if (free_ok_r) begin
              we = 1'b1;
              waddr = free_slot_r;
              wdata.age = count_r[SlotW-1:0];
              valid_nxt[free_slot_r] = 1'b1;
            end else begin
              out_nxt[1:0] = ST_FULL;
            end
          end
          CMD_SCHED: begin
            out_nxt[15:11] = active_r;
            if (best_ok_r) begin
              out_nxt[2] = 1'b1;
              out_nxt[10:3] = best_e_r.id;
              if (best_e_r.rep) begin
                we = 1'b1;
                waddr = best_slot_r;
                wdata = best_e_r;
                wdata.due = time_r + {16'd0, best_e_r.period};
              end else begin
                valid_nxt[best_slot_r] = 1'b0;
                rm_nxt = 1'b1;
                rm_age_nxt = best_e_r.age;
                idx_nxt = '0;
                state_nxt = S_SWEEP;
              end
            end else if (dse_r && active_r == '0) begin
              out_nxt[17:16] = HINT_DEEP;
            end else begin
              out_nxt[17:16] = HINT_IDLE;
            end
          end
          default: begin
            if (!found_r) begin
              out_nxt[1:0] = ST_NOT_FOUND;
            end else begin
              we = 1'b1;
              waddr = found_slot_r;
              wdata = found_e_r;
              case (cmd_r)
                CMD_SUSPEND: wdata.susp = 1'b1;
                CMD_RESUME: wdata.susp = 1'b0;
                CMD_SETPRIO: wdata.prio = prio_r;
                default: begin
                  we = 1'b0;
                  valid_nxt[found_slot_r] = 1'b0;
                  rm_nxt = 1'b1;
                  rm_age_nxt = found_age_r;
                  idx_nxt = '0;
                  state_nxt = S_SWEEP;
                end
              endcase
            end
          end
        endcase
      end
      S_SWEEP: begin
        // Read-modify-write of each valid entry; the write lands in the cycle after
        // the read, never at the address read next.
        if (pv) begin
          we = 1'b1;
          if (rm_r) begin
            if (rdata.age > rm_age_r) begin
              wdata.age = rdata.age - SlotW'(1);
            end
          end else begin
            if (wrap_r) begin
              wdata.due[31] = 1'b0;
            end
            if (rdata.susp) begin
              wdata.due = {wrap_r ? 1'b0 : rdata.due[31], rdata.due[30:0]} + 32'd1;
            end
          end
        end
        if (idx_r == CntW'(MaxTasks)) begin
          state_nxt = S_RESP;
        end else begin
          idx_nxt = idx_r + CntW'(1);
        end
      end
      S_RESP: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      time_r <= '0;
      dse_r <= 1'b0;
      ov_r <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      time_r <= time_nxt;
      ov_r <= ov_nxt;
      idx_r <= idx_nxt;
      if (cfg_valid && cfg_ready) begin
        dse_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tdata[2:0];
      id_r <= in_tdata[10:3];
      tmo_r <= in_tdata[26:11];
      prio_r <= in_tdata[34:27];
      rep_r <= in_tdata[35];
    end
    wrap_r <= wrap_nxt;
    found_r <= found_nxt;
    found_slot_r <= found_slot_nxt;
    found_age_r <= found_age_nxt;
    found_e_r <= found_e_nxt;
    free_ok_r <= free_ok_nxt;
    free_slot_r <= free_slot_nxt;
    best_ok_r <= best_ok_nxt;
    best_slot_r <= best_slot_nxt;
    best_e_r <= best_e_nxt;
    count_r <= count_nxt;
    active_r <= active_nxt;
    rm_r <= rm_nxt;
    rm_age_r <= rm_age_nxt;
    out_r <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("request taken while busy");
  a_resp_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP |=> out_tvalid) else $error("response not presented");
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    time_r <= TimeLimit) else $error("time base out of range");
`endif
endmodule
